[rtl/jmd_pkg.sv]
package jmd_pkg;

  localparam int unsigned JOINT_W     = 4;
  localparam int unsigned POS_W       = 32;
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned TIME_W      = 63;
  localparam int unsigned STALE_W     = 40;
  localparam int unsigned ACT_W       = 4;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 40;
  localparam int unsigned MAG_W       = 32;
  localparam int unsigned NS_W        = 30;
  localparam int unsigned PROD_W      = MAG_W + NS_W;
  localparam int unsigned DIV_STEPS   = 32;
  localparam int unsigned DIV_CNT_W   = 6;
  localparam int unsigned IN_TDATA_W  = 104;
  localparam int unsigned OUT_TDATA_W = 96;

  localparam int unsigned MAX_JOINTS_DEF = 8;

  localparam logic [NS_W-1:0]    NS_PER_S          = 30'd1000000000;
  localparam logic [ACT_W-1:0]   ACTIVE_JOINTS_RST = 4'd8;
  localparam logic [STALE_W-1:0] STALE_NS_RST      = 40'd100000000;

  localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_JOINTS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STALE_NS      = 1'd1;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef struct packed {
    logic load;
    logic read;
    logic delta;
    logic diff;
    logic mul;
    logic div_start;
    logic fin;
    logic phase;
    logic upd_wr;
    logic qry_wr;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic inr;
    logic query;
    logic div_done;
    logic out_free;
  } dp_sts_t;

endpackage

[rtl/jmd_div.sv]
module jmd_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [jmd_pkg::PROD_W-1:0]   num,
  input  logic [jmd_pkg::TIME_W-1:0]   den,
  output logic                         done,
  output logic                         ovf,
  output logic [jmd_pkg::DIV_STEPS-1:0] quot
);

  localparam int unsigned HI_W = jmd_pkg::PROD_W - jmd_pkg::DIV_STEPS;

  logic                              run_r;
  logic                              done_r;
  logic [jmd_pkg::DIV_CNT_W-1:0]     cnt_r;
  logic [jmd_pkg::TIME_W-1:0]        rem_r;
  logic [jmd_pkg::TIME_W-1:0]        rem_nxt;
  logic [jmd_pkg::DIV_STEPS-1:0]     sh_r;
  logic [jmd_pkg::DIV_STEPS-1:0]     q_r;
  logic                              ovf_r;
  logic [jmd_pkg::TIME_W:0]          trial;
  logic                              qbit;
  logic [jmd_pkg::TIME_W-1:0]        num_hi;

  assign num_hi = {{(jmd_pkg::TIME_W-HI_W){1'b0}}, num[jmd_pkg::PROD_W-1:jmd_pkg::DIV_STEPS]};

  always_comb begin
    trial   = {rem_r, sh_r[jmd_pkg::DIV_STEPS-1]};
    qbit    = trial >= {1'b0, den};
    rem_nxt = qbit ? jmd_pkg::TIME_W'(trial - {1'b0, den}) : trial[jmd_pkg::TIME_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= jmd_pkg::DIV_CNT_W'(jmd_pkg::DIV_STEPS);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == jmd_pkg::DIV_CNT_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num_hi;
      sh_r  <= num[jmd_pkg::DIV_STEPS-1:0];
      ovf_r <= num_hi >= den;
      q_r   <= '0;
    end else if (run_r) begin
      rem_r <= rem_nxt;
      sh_r  <= {sh_r[jmd_pkg::DIV_STEPS-2:0], 1'b0};
      q_r   <= {q_r[jmd_pkg::DIV_STEPS-2:0], qbit};
    end
  end

  assign done = done_r;
  assign ovf  = ovf_r;
  assign quot = q_r;

endmodule

[rtl/jmd_dp.sv]
module jmd_dp #(
  parameter int unsigned MAX_JOINTS = jmd_pkg::MAX_JOINTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  jmd_pkg::dp_cmd_t              cmd,
  output jmd_pkg::dp_sts_t              sts,
  input  logic [jmd_pkg::ACT_W-1:0]     cfg_active,
  input  logic [jmd_pkg::STALE_W-1:0]   cfg_stale,
  input  logic                          in_op,
  input  logic [jmd_pkg::JOINT_W-1:0]   in_joint,
  input  logic [jmd_pkg::POS_W-1:0]     in_pos,
  input  logic [jmd_pkg::TIME_W-1:0]    in_time,
  input  logic                          out_ready,
  output logic                          out_vld,
  output logic                          out_inr,
  output logic [jmd_pkg::POS_W-1:0]     out_pos,
  output logic [jmd_pkg::VAL_W-1:0]     out_vel,
  output logic [jmd_pkg::VAL_W-1:0]     out_acc
);

  localparam int unsigned IDX_W = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
  localparam int unsigned CMP_W = jmd_pkg::JOINT_W + 1;

  logic [jmd_pkg::POS_W-1:0]  pos_mem  [MAX_JOINTS];
  logic [jmd_pkg::VAL_W-1:0]  vel_mem  [MAX_JOINTS];
  logic [jmd_pkg::VAL_W-1:0]  acc_mem  [MAX_JOINTS];
  logic [jmd_pkg::TIME_W-1:0] time_mem [MAX_JOINTS];
  logic [MAX_JOINTS-1:0]      vld_r;

  logic                          op_r;
  logic                          inr_r;
  logic [jmd_pkg::JOINT_W-1:0]   joint_r;
  logic [jmd_pkg::POS_W-1:0]     pos_r;
  logic [jmd_pkg::TIME_W-1:0]    time_r;
  logic [jmd_pkg::POS_W-1:0]     old_pos_r;
  logic [jmd_pkg::VAL_W-1:0]     old_vel_r;
  logic [jmd_pkg::VAL_W-1:0]     old_acc_r;
  logic [jmd_pkg::TIME_W-1:0]    old_time_r;
  logic [jmd_pkg::TIME_W-1:0]    dt_r;
  logic                          dt_pos_r;
  logic                          stale_r;
  logic                          neg_r;
  logic                          zero_r;
  logic [jmd_pkg::MAG_W-1:0]     mag_r;
  logic [jmd_pkg::PROD_W-1:0]    prod_r;
  logic [jmd_pkg::VAL_W-1:0]     vel_r;
  logic [jmd_pkg::VAL_W-1:0]     acc_r;
  logic                          out_vld_r;
  logic                          out_inr_r;
  logic [jmd_pkg::POS_W-1:0]     out_pos_r;
  logic [jmd_pkg::VAL_W-1:0]     out_vel_r;
  logic [jmd_pkg::VAL_W-1:0]     out_acc_r;

  logic [IDX_W-1:0]              idx;
  logic [jmd_pkg::TIME_W-1:0]    age;
  logic                          later;
  logic [jmd_pkg::MAG_W:0]       num;
  logic [jmd_pkg::MAG_W:0]       num_abs;
  logic                          div_done;
  logic                          div_ovf;
  logic [jmd_pkg::DIV_STEPS-1:0] quot;
  logic [jmd_pkg::VAL_W-1:0]     rate;

  assign idx   = joint_r[IDX_W-1:0];
  assign age   = time_r - old_time_r;
  assign later = time_r > old_time_r;

  always_comb begin
    if (cmd.phase) begin
      num = {old_vel_r[jmd_pkg::VAL_W-1], old_vel_r};
      num = {vel_r[jmd_pkg::VAL_W-1], vel_r} - num;
    end else begin
      num = {old_pos_r[jmd_pkg::POS_W-1], old_pos_r};
      num = {pos_r[jmd_pkg::POS_W-1], pos_r} - num;
    end
    num_abs = num[jmd_pkg::MAG_W] ? (~num + 1'b1) : num;
  end

  always_comb begin
    if (zero_r) begin
      rate = '0;
    end else if (!dt_pos_r || div_ovf) begin
      rate = neg_r ? jmd_pkg::VAL_MIN : jmd_pkg::VAL_MAX;
    end else if (neg_r) begin
      rate = quot[jmd_pkg::DIV_STEPS-1] ? jmd_pkg::VAL_MIN : (~quot + 1'b1);
    end else begin
      rate = quot[jmd_pkg::DIV_STEPS-1] ? jmd_pkg::VAL_MAX : quot;
    end
  end

  jmd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (prod_r),
    .den   (dt_r),
    .done  (div_done),
    .ovf   (div_ovf),
    .quot  (quot)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_op;
      joint_r <= in_joint;
      pos_r   <= in_pos;
      time_r  <= in_time;
      inr_r   <= ({1'b0, in_joint} < {1'b0, cfg_active}) &&
                 ({1'b0, in_joint} < CMP_W'(MAX_JOINTS));
    end
    if (cmd.read) begin
      old_pos_r  <= vld_r[idx] ? pos_mem[idx]  : '0;
      old_vel_r  <= vld_r[idx] ? vel_mem[idx]  : '0;
      old_acc_r  <= vld_r[idx] ? acc_mem[idx]  : '0;
      old_time_r <= vld_r[idx] ? time_mem[idx] : '0;
    end
    if (cmd.delta) begin
      dt_r     <= age;
      dt_pos_r <= later;
      stale_r  <= later &&
                  (age > {{(jmd_pkg::TIME_W-jmd_pkg::STALE_W){1'b0}}, cfg_stale});
    end
    if (cmd.diff) begin
      neg_r  <= num[jmd_pkg::MAG_W];
      zero_r <= num == '0;
      mag_r  <= num_abs[jmd_pkg::MAG_W-1:0];
    end
    if (cmd.mul) begin
      prod_r <= jmd_pkg::PROD_W'(mag_r) * jmd_pkg::PROD_W'(jmd_pkg::NS_PER_S);
    end
    if (cmd.fin) begin
      if (cmd.phase) begin
        acc_r <= rate;
      end else begin
        vel_r <= rate;
      end
    end
    if (cmd.upd_wr) begin
      pos_mem[idx]  <= pos_r;
      vel_mem[idx]  <= vel_r;
      acc_mem[idx]  <= acc_r;
      time_mem[idx] <= time_r;
    end
    if (cmd.qry_wr && stale_r && vld_r[idx]) begin
      vel_mem[idx] <= '0;
    end
    if (cmd.out_load) begin
      out_inr_r <= inr_r;
      if (!inr_r) begin
        out_pos_r <= '0;
        out_vel_r <= '0;
        out_acc_r <= '0;
      end else if (op_r == jmd_pkg::OP_QUERY) begin
        out_pos_r <= old_pos_r;
        out_vel_r <= stale_r ? '0 : old_vel_r;
        out_acc_r <= old_acc_r;
      end else begin
        out_pos_r <= pos_r;
        out_vel_r <= vel_r;
        out_acc_r <= acc_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (cmd.upd_wr) begin
        vld_r[idx] <= 1'b1;
      end
      if (cmd.out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign sts.inr      = inr_r;
  assign sts.query    = op_r == jmd_pkg::OP_QUERY;
  assign sts.div_done = div_done;
  assign sts.out_free = !out_vld_r || out_ready;

  assign out_vld = out_vld_r;
  assign out_inr = out_inr_r;
  assign out_pos = out_pos_r;
  assign out_vel = out_vel_r;
  assign out_acc = out_acc_r;

endmodule

[rtl/jmd_ctrl.sv]
module jmd_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  jmd_pkg::dp_sts_t sts,
  output jmd_pkg::dp_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_DELTA,
    ST_DIFF_V,
    ST_MUL_V,
    ST_DIV_V,
    ST_WAIT_V,
    ST_DIFF_A,
    ST_MUL_A,
    ST_DIV_A,
    ST_WAIT_A,
    ST_UPD_WR,
    ST_QRY_WR,
    ST_FINISH
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   in_ready_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        cmd.load = in_valid && in_ready_r;
        if (cmd.load) state_nxt = ST_READ;
      end
      ST_READ: begin
        cmd.read  = 1'b1;
        state_nxt = ST_DELTA;
      end
      ST_DELTA: begin
        cmd.delta = 1'b1;
        if (!sts.inr) state_nxt = ST_FINISH;
        else if (sts.query) state_nxt = ST_QRY_WR;
        else state_nxt = ST_DIFF_V;
      end
      ST_DIFF_V: begin
        cmd.diff  = 1'b1;
        state_nxt = ST_MUL_V;
      end
      ST_MUL_V: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_DIV_V;
      end
      ST_DIV_V: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_WAIT_V;
      end
      ST_WAIT_V: begin
        cmd.fin = sts.div_done;
        if (sts.div_done) state_nxt = ST_DIFF_A;
      end
      ST_DIFF_A: begin
        cmd.diff  = 1'b1;
        cmd.phase = 1'b1;
        state_nxt = ST_MUL_A;
      end
      ST_MUL_A: begin
        cmd.mul   = 1'b1;
        cmd.phase = 1'b1;
        state_nxt = ST_DIV_A;
      end
      ST_DIV_A: begin
        cmd.div_start = 1'b1;
        cmd.phase     = 1'b1;
        state_nxt     = ST_WAIT_A;
      end
      ST_WAIT_A: begin
        cmd.fin   = sts.div_done;
        cmd.phase = 1'b1;
        if (sts.div_done) state_nxt = ST_UPD_WR;
      end
      ST_UPD_WR: begin
        cmd.upd_wr = 1'b1;
        state_nxt  = ST_FINISH;
      end
      ST_QRY_WR: begin
        cmd.qry_wr = 1'b1;
        state_nxt  = ST_FINISH;
      end
      ST_FINISH: begin
        cmd.out_load = sts.out_free;
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= state_nxt == ST_IDLE;
    end
  end

  assign in_ready = in_ready_r;

endmodule

[rtl/joint_motion_differentiator.sv]
// Per-joint finite-difference velocity and acceleration estimator.
// Input beats (in_*): tuser selects update or query; tdata carries the joint
// index, a Q16.16 position and a 63-bit nanosecond timestamp. Each input beat
// yields exactly one output beat (out_*): tuser flags an in-range joint,
// tdata returns position, velocity and acceleration (zeros when out of range).
// An update forms velocity = dpos*1e9/dt and acceleration = dvel*1e9/dt with
// 32-bit saturation; a query returns stored values and zeroes a velocity
// older than stale_ns.
// An update runs two serial 32-step restoring divisions on one shared
// divider; a query and an out-of-range joint skip the divisions. One beat is
// processed at a time; in_tready rises again once the result sits in the
// output register.
// Write config (cfg_we, cfg_index, cfg_wdata) only while no beat is in flight.
// Reset clears all joint state, loads active_joints = 8 and
// stale_ns = 100000000, and empties the output register.
// A stalled receiver holds the output beat; the next input beat may be
// accepted meanwhile, but its result waits until the output register frees.
module joint_motion_differentiator #(
  parameter int unsigned MAX_JOINTS = jmd_pkg::MAX_JOINTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // joint_index, position, time_ns, zero pad
  input  logic [jmd_pkg::IN_TDATA_W-1:0]     in_tdata,
  // operation
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // position_out, velocity_out, acceleration_out
  output logic [jmd_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // in_range
  output logic                               out_tuser,
  input  logic                               cfg_we,
  input  logic [jmd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [jmd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int unsigned POS_LO  = jmd_pkg::JOINT_W;
  localparam int unsigned TIME_LO = POS_LO + jmd_pkg::POS_W;

  logic [jmd_pkg::ACT_W-1:0]   active_r;
  logic [jmd_pkg::STALE_W-1:0] stale_r;
  jmd_pkg::dp_cmd_t            dp_cmd;
  jmd_pkg::dp_sts_t            dp_sts;
  logic [jmd_pkg::POS_W-1:0]   res_pos;
  logic [jmd_pkg::VAL_W-1:0]   res_vel;
  logic [jmd_pkg::VAL_W-1:0]   res_acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= jmd_pkg::ACTIVE_JOINTS_RST;
      stale_r  <= jmd_pkg::STALE_NS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        jmd_pkg::REG_ACTIVE_JOINTS: active_r <= cfg_wdata[jmd_pkg::ACT_W-1:0];
        jmd_pkg::REG_STALE_NS:      stale_r  <= cfg_wdata[jmd_pkg::STALE_W-1:0];
        default: ;
      endcase
    end
  end

  jmd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (dp_sts),
    .cmd      (dp_cmd)
  );

  jmd_dp #(
    .MAX_JOINTS (MAX_JOINTS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (dp_cmd),
    .sts        (dp_sts),
    .cfg_active (active_r),
    .cfg_stale  (stale_r),
    .in_op      (in_tuser),
    .in_joint   (in_tdata[jmd_pkg::JOINT_W-1:0]),
    .in_pos     (in_tdata[TIME_LO-1:POS_LO]),
    .in_time    (in_tdata[TIME_LO+jmd_pkg::TIME_W-1:TIME_LO]),
    .out_ready  (out_tready),
    .out_vld    (out_tvalid),
    .out_inr    (out_tuser),
    .out_pos    (res_pos),
    .out_vel    (res_vel),
    .out_acc    (res_acc)
  );

  assign out_tdata = {res_acc, res_vel, res_pos};

  a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted twice in a row");

  a_out_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("out-of-range result carries nonzero values");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.out_load |-> (!out_tvalid || out_tready))
    else $error("result overwrote a pending output beat");

endmodule
